// File: rtl/psdhp_pkg.sv
// Shared types, phase codes and constants for the layered-image header parser.
// No dependencies; the parse, buffer, top-level and checker files import this package.
package psdhp_pkg;

  localparam int PhaseW = 5;

  // Parse phases, one per header field.
  localparam logic [PhaseW-1:0] PH_SIG0  = 5'd0;
  localparam logic [PhaseW-1:0] PH_VER   = 5'd4;
  localparam logic [PhaseW-1:0] PH_RESV  = 5'd5;
  localparam logic [PhaseW-1:0] PH_CHAN  = 5'd6;
  localparam logic [PhaseW-1:0] PH_HGT   = 5'd7;
  localparam logic [PhaseW-1:0] PH_WID   = 5'd8;
  localparam logic [PhaseW-1:0] PH_DEP   = 5'd9;
  localparam logic [PhaseW-1:0] PH_MODE  = 5'd10;
  localparam logic [PhaseW-1:0] PH_LEN1  = 5'd11;
  localparam logic [PhaseW-1:0] PH_SKIP1 = 5'd12;
  localparam logic [PhaseW-1:0] PH_LEN2  = 5'd13;
  localparam logic [PhaseW-1:0] PH_SKIP2 = 5'd14;
  localparam logic [PhaseW-1:0] PH_LEN3  = 5'd15;
  localparam logic [PhaseW-1:0] PH_SKIP3 = 5'd16;
  localparam logic [PhaseW-1:0] PH_COMP  = 5'd17;

  // Verdict codes.
  localparam logic [1:0] STATUS_PARSING  = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  localparam logic [31:0] RESERVED_BYTES = 32'd6;
  localparam logic [31:0] DEPTH_8        = 32'd8;
  localparam logic [31:0] DEPTH_16       = 32'd16;
  localparam logic [31:0] CHAN_GREY      = 32'd1;
  localparam logic [31:0] CHAN_COLOR     = 32'd3;
  localparam logic [31:0] VERSION_ONE    = 32'd1;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] image_height;
    logic [31:0] image_width;
    logic        sixteen_bit;
    logic [1:0]  channel_count;
  } result_t;

  // Signature letters "8BPS".
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h38;
      2'd1:    val = 8'h42;
      2'd2:    val = 8'h50;
      default: val = 8'h53;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/psdhp_in_if.sv
// Byte channel into the header parser: valid/ready handshake plus payload.
// Stands alone; used by the top level.
interface psdhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

// File: rtl/psdhp_out_if.sv
// Result channel out of the header parser: valid/ready handshake plus payload.
// Stands alone; used by the top level.
interface psdhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] image_height;
  logic [31:0] image_width;
  logic        sixteen_bit;
  logic [1:0]  channel_count;

  modport source (output valid, output status, output image_height, output image_width,
                  output sixteen_bit, output channel_count, input ready);
  modport sink   (input valid, input status, input image_height, input image_width,
                  input sixteen_bit, input channel_count, output ready);
endinterface

// File: rtl/psdhp_parse.sv
// Header parse state and the per-byte next-state and result logic.
// Depends on psdhp_pkg.
module psdhp_parse
  import psdhp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [7:0]    data_byte,
  input  logic          start_req,
  output result_t       res
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [31:0]       asm_r, asm_nxt;
  logic [31:0]       skip_r, skip_nxt;
  logic [1:0]        chan_r, chan_nxt;
  logic [31:0]       hgt_r, hgt_nxt;
  logic [31:0]       wid_r, wid_nxt;
  logic              dep16_r, dep16_nxt;
  logic [1:0]        done_r, done_nxt;

  logic [31:0] asm_col;
  logic [1:0]  idx_inc;
  logic        last2, last4;
  logic [31:0] skip_dec;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    asm_nxt   = asm_r;
    skip_nxt  = skip_r;
    chan_nxt  = chan_r;
    hgt_nxt   = hgt_r;
    wid_nxt   = wid_r;
    dep16_nxt = dep16_r;
    done_nxt  = done_r;

    // A start request clears everything before the byte is taken.
    if (start_req) begin
      phase_nxt = PH_SIG0;
      idx_nxt   = 2'd0;
      asm_nxt   = 32'd0;
      skip_nxt  = 32'd0;
      chan_nxt  = 2'd0;
      hgt_nxt   = 32'd0;
      wid_nxt   = 32'd0;
      dep16_nxt = 1'b0;
      done_nxt  = STATUS_PARSING;
    end

    asm_col  = (idx_nxt == 2'd0) ? {24'd0, data_byte} : {asm_nxt[23:0], data_byte};
    idx_inc  = idx_nxt + 2'd1;
    last2    = (idx_nxt != 2'd0);
    last4    = (idx_nxt == 2'd3);
    skip_dec = (skip_nxt != 32'd0) ? skip_nxt - 32'd1 : skip_nxt;

    if (done_nxt == STATUS_PARSING) begin
      if (phase_nxt < PH_VER) begin
        if (data_byte != sig_byte(phase_nxt[1:0])) done_nxt = STATUS_REJECTED;
        else phase_nxt = phase_nxt + 5'd1;
      end else begin
        unique case (phase_nxt) inside
          PH_VER: begin
            asm_nxt = asm_col;
            idx_nxt = last2 ? 2'd0 : idx_inc;
            if (last2) begin
              if (asm_col != VERSION_ONE) begin
                done_nxt = STATUS_REJECTED;
              end else begin
                skip_nxt  = RESERVED_BYTES;
                phase_nxt = PH_RESV;
              end
            end
          end
          PH_RESV, PH_SKIP1, PH_SKIP2, PH_SKIP3: begin
            skip_nxt = skip_dec;
            if (skip_dec == 32'd0) phase_nxt = phase_nxt + 5'd1;
          end
          PH_CHAN: begin
            asm_nxt = asm_col;
            idx_nxt = last2 ? 2'd0 : idx_inc;
            if (last2) begin
              if (asm_col != CHAN_GREY && asm_col != CHAN_COLOR) begin
                done_nxt = STATUS_REJECTED;
              end else begin
                chan_nxt  = asm_col[1:0];
                phase_nxt = PH_HGT;
              end
            end
          end
          PH_HGT: begin
            asm_nxt = asm_col;
            idx_nxt = last4 ? 2'd0 : idx_inc;
            if (last4) begin
              hgt_nxt   = asm_col;
              phase_nxt = PH_WID;
            end
          end
          PH_WID: begin
            asm_nxt = asm_col;
            idx_nxt = last4 ? 2'd0 : idx_inc;
            if (last4) begin
              wid_nxt   = asm_col;
              phase_nxt = PH_DEP;
            end
          end
          PH_DEP: begin
            asm_nxt = asm_col;
            idx_nxt = last2 ? 2'd0 : idx_inc;
            if (last2) begin
              if (asm_col != DEPTH_8 && asm_col != DEPTH_16) begin
                done_nxt = STATUS_REJECTED;
              end else begin
                dep16_nxt = (asm_col == DEPTH_16);
                phase_nxt = PH_MODE;
              end
            end
          end
          PH_MODE: begin
            asm_nxt = asm_col;
            idx_nxt = last2 ? 2'd0 : idx_inc;
            if (last2) begin
              if (asm_col != {30'd0, chan_nxt}) done_nxt = STATUS_REJECTED;
              else phase_nxt = PH_LEN1;
            end
          end
          PH_LEN1, PH_LEN2, PH_LEN3: begin
            asm_nxt = asm_col;
            idx_nxt = last4 ? 2'd0 : idx_inc;
            if (last4) begin
              // Zero or top-bit-set length: skip over the body phase.
              if (asm_col != 32'd0 && !asm_col[31]) begin
                skip_nxt  = asm_col;
                phase_nxt = phase_nxt + 5'd1;
              end else begin
                phase_nxt = phase_nxt + 5'd2;
              end
            end
          end
          PH_COMP: begin
            asm_nxt = asm_col;
            idx_nxt = last2 ? 2'd0 : idx_inc;
            if (last2) done_nxt = (asm_col == 32'd0) ? STATUS_ACCEPTED : STATUS_REJECTED;
          end
          default: begin
          end
        endcase
      end
    end

    res.status        = done_nxt;
    res.image_height  = (done_nxt == STATUS_ACCEPTED) ? hgt_nxt   : 32'd0;
    res.image_width   = (done_nxt == STATUS_ACCEPTED) ? wid_nxt   : 32'd0;
    res.sixteen_bit   = (done_nxt == STATUS_ACCEPTED) ? dep16_nxt : 1'b0;
    res.channel_count = (done_nxt == STATUS_ACCEPTED) ? chan_nxt  : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG0;
      idx_r   <= 2'd0;
      asm_r   <= 32'd0;
      skip_r  <= 32'd0;
      chan_r  <= 2'd0;
      hgt_r   <= 32'd0;
      wid_r   <= 32'd0;
      dep16_r <= 1'b0;
      done_r  <= STATUS_PARSING;
    end else if (acc) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      asm_r   <= asm_nxt;
      skip_r  <= skip_nxt;
      chan_r  <= chan_nxt;
      hgt_r   <= hgt_nxt;
      wid_r   <= wid_nxt;
      dep16_r <= dep16_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// File: rtl/psdhp_outbuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on psdhp_pkg for the result word type.
module psdhp_outbuf
  import psdhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_res_r, skid_res_r;
  logic    acc;
  logic    drain;

  assign in_ready  = !skid_valid_r;
  assign acc       = in_valid && !skid_valid_r;
  assign drain     = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (drain) begin
      out_valid_nxt  = skid_valid_r || acc;
      skid_valid_nxt = 1'b0;
    end else if (acc) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) out_res_r <= skid_res_r;
      else if (acc)     out_res_r <= in_res;
    end else if (acc) begin
      skid_res_r <= in_res;
    end
  end

endmodule

// File: rtl/psd_header_parser.sv
// Top level of the layered-image header parser.
// Depends on psdhp_pkg, psdhp_in_if, psdhp_out_if, psdhp_parse and psdhp_outbuf.
//
// The parser takes one file byte per word, most significant byte first, and
// returns exactly one result word for every byte taken. A byte with start_req
// set restarts parsing and is read as the first signature letter. Each byte
// is handled by one layer of compare, shift and decrement logic on the parse
// state and the byte, whose result is registered, so the throughput is one
// byte per clock while in_ch.ready is high. Results sit in a two-entry buffer
// (an output register, backed by a skid register that takes a result while the
// output is stalled), so the input keeps taking bytes while
// a result waits; in_ch.ready drops only when both entries are full and
// returns the cycle after the consumer takes a word. Status reads 0 while
// parsing, 1 once the compression word closes a good header and 2 from the
// first failed check; the verdict then repeats on every byte until the next
// start. Height, width, depth flag and channel count are zero unless the
// status is 1. There are no configuration registers and no clearing pass.
module psd_header_parser
  import psdhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  psdhp_in_if.sink    in_ch,
  psdhp_out_if.source out_ch
);

  result_t parse_res;
  result_t buf_res;
  logic    buf_in_ready;
  logic    in_acc;

  // Take a byte when the buffer has room.
  assign in_acc      = in_ch.valid && buf_in_ready;
  assign in_ch.ready = buf_in_ready;

  psdhp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .data_byte (in_ch.data_byte),
    .start_req (in_ch.start_req),
    .res       (parse_res)
  );

  psdhp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (buf_in_ready),
    .in_res    (parse_res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (buf_res)
  );

  // Spread the buffered word onto the result channel.
  assign out_ch.status        = buf_res.status;
  assign out_ch.image_height  = buf_res.image_height;
  assign out_ch.image_width   = buf_res.image_width;
  assign out_ch.sixteen_bit   = buf_res.sixteen_bit;
  assign out_ch.channel_count = buf_res.channel_count;

endmodule

// File: rtl/psdhp_checker.sv
// Port-level assertions for the header parser, bound to the top level.
// Depends on psdhp_pkg and psd_header_parser.
module psdhp_checker
  import psdhp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] image_height,
  input logic [31:0] image_width,
  input logic        sixteen_bit,
  input logic [1:0]  channel_count
);

  // No result may be left over from before reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == STATUS_PARSING || status == STATUS_ACCEPTED ||
                   status == STATUS_REJECTED))
    else $error("unknown status code");

  // Fields stay zero unless the header was accepted.
  a_fields_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != STATUS_ACCEPTED) |->
      (image_height == 32'd0 && image_width == 32'd0 &&
       !sixteen_bit && channel_count == 2'd0))
    else $error("fields set without an accepted header");

  // An accepted header always carries one or three channels.
  a_accepted_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == STATUS_ACCEPTED) |->
      (channel_count == 2'd1 || channel_count == 2'd3))
    else $error("accepted header with bad channel count");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
                                   $stable(image_height) && $stable(image_width)))
    else $error("stalled result changed");

endmodule

bind psd_header_parser psdhp_checker u_psdhp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .image_height  (out_ch.image_height),
  .image_width   (out_ch.image_width),
  .sixteen_bit   (out_ch.sixteen_bit),
  .channel_count (out_ch.channel_count)
);
